[rtl/stack_machine_execute_unit_macros.svh]
// Assertion macros for the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define SME_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/sme_pkg.sv]
// Package with opcodes, fault codes and sizes for the stack machine execute unit.
package sme_pkg;
   localparam int RegisterCount = 16;
   localparam int MemoryDepth   = 256;
   localparam int StackDepth    = 256;
   localparam int ReturnDepth   = 64;

   localparam logic [4:0] OP_PUSH = 5'd1;
   localparam logic [4:0] OP_POP  = 5'd2;
   localparam logic [4:0] OP_ADD  = 5'd3;
   localparam logic [4:0] OP_SUB  = 5'd4;
   localparam logic [4:0] OP_MUL  = 5'd5;
   localparam logic [4:0] OP_DIV  = 5'd6;
   localparam logic [4:0] OP_HALT = 5'd8;
   localparam logic [4:0] OP_JNE  = 5'd9;
   localparam logic [4:0] OP_JA   = 5'd10;
   localparam logic [4:0] OP_CALL = 5'd11;
   localparam logic [4:0] OP_RET  = 5'd12;
   localparam logic [4:0] OP_DRAW = 5'd13;
   localparam logic [4:0] OP_JE   = 5'd14;
   localparam logic [4:0] OP_JB   = 5'd15;
   localparam logic [4:0] OP_SQRT = 5'd16;
   localparam logic [4:0] OP_IN   = 5'd17;
   localparam logic [4:0] OP_OUT  = 5'd18;

   localparam logic [2:0] FLT_NONE  = 3'd0;
   localparam logic [2:0] FLT_UNDER = 3'd1;
   localparam logic [2:0] FLT_OVER  = 3'd2;
   localparam logic [2:0] FLT_DIV0  = 3'd3;
   localparam logic [2:0] FLT_OPC   = 3'd4;
   localparam logic [2:0] FLT_ADDR  = 3'd5;

   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [31:0] num;
      logic [31:0] den;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } iter_rsp_type;
endpackage

[rtl/sme_iter.sv]
// Shared iterative unit: signed divide or integer square root, one bit per cycle.
module sme_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  sme_pkg::iter_req_type req,
   output sme_pkg::iter_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;   // quotient or root being built
   logic [32:0] rem_ff, rem_in;   // partial remainder
   logic [31:0] num_ff, num_in;   // dividend or radicand shifted out from the top
   logic [31:0] den_ff, den_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] strial;
   logic [33:0] rem2;

   always_comb begin
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = '0;
      rem2    = '0;
      strial  = '0;
      if (req.start) begin
         busy_in = 1'b1;
         sqrt_in = req.is_sqrt;
         neg_in  = req.num[31] ^ req.den[31];
         num_in  = (req.num[31] && !req.is_sqrt) ? 32'd0 - req.num : req.num;
         den_in  = req.den[31] ? 32'd0 - req.den : req.den;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            // Two radicand bits per step; 16 steps.
            rem2   = {rem_ff[31:0], num_ff[31:30]};
            strial = {16'd0, quo_ff[15:0], 2'b01};
            if (rem2 >= strial) begin
               rem_in = rem2[32:0] - strial[32:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem2[32:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            num_in = {num_ff[29:0], 2'b00};
            if (cnt_ff == 6'd15) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            trial = {rem_ff[31:0], num_ff[31]};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            num_in = {num_ff[30:0], 1'b0};
            if (cnt_ff == 6'd31) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               if (neg_ff) quo_in = 32'd0 - quo_in;
            end
         end
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = quo_ff;
endmodule

[rtl/stack_machine_execute_unit.sv]
// Top level of the stack machine execute unit.
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | type, mode, immediate, register, input value
// rsp     | out       | rsp_valid/rsp_stall | next pc, out valid/value, halted, fault
// One instruction at a time: the register file is read at the transfer, the stack
// and memory arrays in a read cycle, then an execute cycle writes back.
// Divide and non-negative square root wait in ST_ITER for the shared iterative unit.
// Data memory and register file are cleared by a pass over all their addresses
// after reset; no request is taken during it.
// A stalled result is held in the output register; the next request waits for it.
module stack_machine_execute_unit #(
   parameter int REGISTER_COUNT = sme_pkg::RegisterCount,
   parameter int MEMORY_DEPTH   = sme_pkg::MemoryDepth,
   parameter int STACK_DEPTH    = sme_pkg::StackDepth,
   parameter int RETURN_DEPTH   = sme_pkg::ReturnDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_type,
   input  logic [2:0]         req_arg_mode,
   input  logic signed [31:0] req_immediate,
   input  logic [3:0]         req_reg_select,
   input  logic signed [31:0] req_input_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_next_pc,
   output logic               rsp_out_valid,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_halted,
   output logic [2:0]         rsp_fault
);
`include "stack_machine_execute_unit_macros.svh"

   localparam int RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam int MW = $clog2(MEMORY_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int TW = $clog2(RETURN_DEPTH);
   localparam int CW = (MW > RW) ? MW : RW;
   localparam int CLR_N = (MEMORY_DEPTH > REGISTER_COUNT) ? MEMORY_DEPTH : REGISTER_COUNT;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_ITER  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [7:0]  ret_mem   [RETURN_DEPTH];
   logic [31:0] reg_mem   [REGISTER_COUNT];
   logic [31:0] data_mem  [MEMORY_DEPTH];

   logic [7:0]  pc_ff, pc_in;
   logic [SW:0] sd_ff, sd_in;
   logic [TW:0] rd_ff, rd_in;
   logic        halt_ff, halt_in;
   logic [CW:0] clr_ff, clr_in;

   logic [4:0]  op_ff;
   logic [2:0]  mode_ff;
   logic [31:0] imm_ff, inv_ff;
   logic [3:0]  rsel_ff;

   // Registered read data.
   logic [31:0] top_rd_ff, sec_rd_ff, reg_rd_ff, mem_rd_ff;
   logic [7:0]  ret_rd_ff;
   logic [31:0] arg_ff;
   logic        reg_bad_ff;

   logic [7:0]  o_pc_ff, o_pc_in;
   logic        o_ov_ff, o_ov_in;
   logic [31:0] o_val_ff, o_val_in;
   logic        o_halt_ff, o_halt_in;
   logic [2:0]  o_fault_ff, o_fault_in;

   sme_pkg::iter_req_type it_req;
   sme_pkg::iter_rsp_type it_rsp;

   sme_iter u_iter (.clock(clock), .reset(reset), .req(it_req), .rsp(it_rsp));

   logic        accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Read addresses from the captured instruction (fixed-width operand sum).
   logic [31:0] reg_word;
   logic [31:0] arg_sum;
   logic [SW-1:0] top_idx, sec_idx;
   assign top_idx = sd_ff[SW-1:0] - SW'(1);
   assign sec_idx = sd_ff[SW-1:0] - SW'(2);

   // Write control from the execute stage.
   logic          st_we;
   logic [SW-1:0] st_wa;
   logic [31:0]   st_wd;
   logic          rt_we;
   logic          rg_we;
   logic [RW-1:0] rg_wa;
   logic [31:0]   rg_wd;
   logic          dm_we;
   logic [MW-1:0] dm_wa;
   logic [31:0]   dm_wd;

   logic [2:0]  flt;
   logic [7:0]  nxt;
   logic        take;
   logic        go_iter;
   logic [31:0] res;
   logic        ovf;
   logic [31:0] ov;
   logic [7:0]  len;
   logic        wide;
   logic [31:0] prod;
   logic signed [31:0] sa, sb;

   assign prod = top_rd_ff * sec_rd_ff;
   assign sa   = top_rd_ff;
   assign sb   = sec_rd_ff;

   always_comb begin
      flt = sme_pkg::FLT_NONE;
      nxt = pc_ff + 8'd1;
      take = 1'b0;
      go_iter = 1'b0;
      res = '0;
      ovf = 1'b0;
      ov = '0;
      st_we = 1'b0; st_wa = sd_ff[SW-1:0]; st_wd = '0;
      rt_we = 1'b0;
      rg_we = 1'b0; rg_wa = RW'(rsel_ff); rg_wd = top_rd_ff;
      dm_we = 1'b0; dm_wa = arg_ff[MW-1:0]; dm_wd = top_rd_ff;
      sd_in = sd_ff; rd_in = rd_ff; halt_in = halt_ff;
      len = 8'd2 + {7'd0, mode_ff[0]} + {7'd0, mode_ff[1]};
      wide = (arg_ff >= 32'(MEMORY_DEPTH));
      case (op_ff)
         sme_pkg::OP_PUSH: begin
            if (reg_bad_ff || (mode_ff[2] && wide) || mode_ff == 3'd0)
               flt = sme_pkg::FLT_ADDR;
            else if (sd_ff >= (SW+1)'(STACK_DEPTH)) flt = sme_pkg::FLT_OVER;
            else begin
               st_we = 1'b1;
               st_wd = mode_ff[2] ? mem_rd_ff : arg_ff;
               sd_in = sd_ff + (SW+1)'(1);
               nxt = pc_ff + len;
            end
         end
         sme_pkg::OP_POP: begin
            if (reg_bad_ff || (mode_ff[2] && wide) || (!mode_ff[2] && mode_ff != 3'd2))
               flt = sme_pkg::FLT_ADDR;
            else if (sd_ff == '0) flt = sme_pkg::FLT_UNDER;
            else begin
               sd_in = sd_ff - (SW+1)'(1);
               if (mode_ff[2]) dm_we = 1'b1;
               else rg_we = 1'b1;
               nxt = pc_ff + len;
            end
         end
         sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
            if (sd_ff < (SW+1)'(2)) flt = sme_pkg::FLT_UNDER;
            else if (op_ff == sme_pkg::OP_DIV && top_rd_ff == '0) flt = sme_pkg::FLT_DIV0;
            else begin
               st_wa = sec_idx;
               case (op_ff)
                  sme_pkg::OP_ADD: res = top_rd_ff + sec_rd_ff;
                  sme_pkg::OP_SUB: res = sec_rd_ff - top_rd_ff;
                  sme_pkg::OP_MUL: res = prod;
                  default:         res = '0;
               endcase
               if (op_ff == sme_pkg::OP_DIV) go_iter = 1'b1;
               else begin
                  st_we = 1'b1; st_wd = res; sd_in = sd_ff - (SW+1)'(1);
               end
            end
         end
         sme_pkg::OP_JNE, sme_pkg::OP_JA, sme_pkg::OP_JE, sme_pkg::OP_JB: begin
            case (op_ff)
               sme_pkg::OP_JNE: take = sa != sb;
               sme_pkg::OP_JA:  take = sa > sb;
               sme_pkg::OP_JE:  take = sa == sb;
               default:         take = sa < sb;
            endcase
            if (sd_ff < (SW+1)'(2)) flt = sme_pkg::FLT_UNDER;
            else if (take && imm_ff > 32'd255) flt = sme_pkg::FLT_ADDR;
            else begin
               sd_in = sd_ff - (SW+1)'(2);
               nxt = take ? imm_ff[7:0] : pc_ff + 8'd2;
            end
         end
         sme_pkg::OP_HALT: begin
            halt_in = 1'b1;
            nxt = pc_ff;
         end
         sme_pkg::OP_CALL: begin
            if (imm_ff > 32'd255) flt = sme_pkg::FLT_ADDR;
            else if (rd_ff >= (TW+1)'(RETURN_DEPTH)) flt = sme_pkg::FLT_OVER;
            else begin
               rt_we = 1'b1; rd_in = rd_ff + (TW+1)'(1); nxt = imm_ff[7:0];
            end
         end
         sme_pkg::OP_RET: begin
            if (rd_ff == '0) flt = sme_pkg::FLT_UNDER;
            else begin
               rd_in = rd_ff - (TW+1)'(1); nxt = ret_rd_ff;
            end
         end
         sme_pkg::OP_DRAW: ;
         sme_pkg::OP_SQRT: begin
            if (sd_ff == '0) flt = sme_pkg::FLT_UNDER;
            else begin
               st_wa = top_idx;
               if (top_rd_ff[31]) begin
                  st_we = 1'b1; st_wd = '0;
               end else go_iter = 1'b1;
            end
         end
         sme_pkg::OP_IN: begin
            if (sd_ff >= (SW+1)'(STACK_DEPTH)) flt = sme_pkg::FLT_OVER;
            else begin
               st_we = 1'b1; st_wd = inv_ff; sd_in = sd_ff + (SW+1)'(1);
            end
         end
         sme_pkg::OP_OUT: begin
            if (sd_ff == '0) flt = sme_pkg::FLT_UNDER;
            else begin
               ovf = 1'b1; ov = top_rd_ff; sd_in = sd_ff - (SW+1)'(1);
            end
         end
         default: flt = sme_pkg::FLT_OPC;
      endcase
      if (halt_ff) begin
         flt = sme_pkg::FLT_NONE;
         go_iter = 1'b0;
      end
      if (flt != sme_pkg::FLT_NONE || halt_ff) begin
         nxt = pc_ff; ovf = 1'b0; ov = '0;
         st_we = 1'b0; rt_we = 1'b0; rg_we = 1'b0; dm_we = 1'b0;
         sd_in = sd_ff; rd_in = rd_ff; halt_in = halt_ff; go_iter = 1'b0;
      end
   end

   assign it_req.start   = (state_ff == ST_EXEC) && go_iter;
   assign it_req.is_sqrt = (op_ff == sme_pkg::OP_SQRT);
   assign it_req.num     = (op_ff == sme_pkg::OP_SQRT) ? top_rd_ff : sec_rd_ff;
   assign it_req.den     = top_rd_ff;

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      clr_in = clr_ff;
      o_pc_in = o_pc_ff; o_ov_in = o_ov_ff; o_val_in = o_val_ff;
      o_halt_in = o_halt_ff; o_fault_in = o_fault_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + (CW+1)'(1);
            if (clr_ff == (CW+1)'(CLR_N - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            o_fault_in = flt;
            o_ov_in = ovf; o_val_in = ov;
            o_halt_in = halt_in;
            if (go_iter) state_in = ST_ITER;
            else begin
               pc_in = nxt; o_pc_in = nxt; state_in = ST_RESP;
            end
         end
         ST_ITER: if (it_rsp.done) begin
            pc_in = pc_ff + 8'd1; o_pc_in = pc_ff + 8'd1; state_in = ST_RESP;
         end
         ST_RESP: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pc_ff <= '0; sd_ff <= '0; rd_ff <= '0; halt_ff <= 1'b0; clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         clr_ff <= clr_in;
         if (state_ff == ST_EXEC) begin
            sd_ff <= sd_in; rd_ff <= rd_in; halt_ff <= halt_in;
         end
         if (state_ff == ST_ITER && it_rsp.done && op_ff == sme_pkg::OP_DIV)
            sd_ff <= sd_ff - (SW+1)'(1);
      end
      o_pc_ff <= o_pc_in; o_ov_ff <= o_ov_in; o_val_ff <= o_val_in;
      o_halt_ff <= o_halt_in; o_fault_ff <= o_fault_in;
      if (accept) begin
         op_ff <= req_type; mode_ff <= req_arg_mode; imm_ff <= req_immediate;
         rsel_ff <= req_reg_select; inv_ff <= req_input_value;
      end
   end

   // Operand: immediate and/or the register word read at the transfer, by mode.
   assign reg_word = reg_rd_ff;
   assign arg_sum  = (mode_ff[0] ? imm_ff : 32'd0) + (mode_ff[1] ? reg_word : 32'd0);

   // Memory ports. The register file is read at the transfer, the stacks and the
   // data memory in the read cycle; all are written in execute, iterative results in ST_ITER.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         reg_rd_ff  <= reg_mem[RW'(req_reg_select)];
         reg_bad_ff <= req_arg_mode[1] && (32'(req_reg_select) >= 32'(REGISTER_COUNT));
      end
      if (state_ff == ST_READ) begin
         top_rd_ff <= stack_mem[top_idx];
         sec_rd_ff <= stack_mem[sec_idx];
         ret_rd_ff <= ret_mem[rd_ff[TW-1:0] - TW'(1)];
         arg_ff    <= arg_sum;
         mem_rd_ff <= data_mem[arg_sum[MW-1:0]];
      end
      if (state_ff == ST_CLEAR) begin
         if (clr_ff < (CW+1)'(MEMORY_DEPTH)) data_mem[clr_ff[MW-1:0]] <= '0;
         if (clr_ff < (CW+1)'(REGISTER_COUNT)) reg_mem[clr_ff[RW-1:0]] <= '0;
      end else if (state_ff == ST_EXEC) begin
         if (dm_we) data_mem[dm_wa] <= dm_wd;
         if (rg_we) reg_mem[rg_wa] <= rg_wd;
      end
      if (state_ff == ST_EXEC && st_we) stack_mem[st_wa] <= st_wd;
      if (state_ff == ST_ITER && it_rsp.done) begin
         if (op_ff == sme_pkg::OP_DIV) stack_mem[sec_idx] <= it_rsp.result;
         else stack_mem[top_idx] <= it_rsp.result;
      end
      if (state_ff == ST_EXEC && rt_we) ret_mem[rd_ff[TW-1:0]] <= pc_ff + 8'd2;
   end

   assign rsp_valid     = (state_ff == ST_RESP);
   assign rsp_next_pc   = o_pc_ff;
   assign rsp_out_valid = o_ov_ff;
   assign rsp_out_value = o_val_ff;
   assign rsp_halted    = o_halt_ff;
   assign rsp_fault     = o_fault_ff;

   `SME_ASSERT_IMPL(a_no_take_busy, clock, reset, state_ff != ST_IDLE, req_stall, "request taken while busy")
   `SME_ASSERT_NEXT(a_read_exec, clock, reset, state_ff == ST_READ, state_ff == ST_EXEC, "read not followed by execute")
   `SME_ASSERT_IMPL(a_fault_no_out, clock, reset, rsp_valid && rsp_fault != sme_pkg::FLT_NONE, !rsp_out_valid, "out value with fault")
   `SME_ASSERT_IMPL(a_pc_match, clock, reset, rsp_valid, rsp_next_pc == pc_ff, "result pc differs from state")
endmodule
